// ===== rtl/core/pnh_pkg.sv =====
// ----------------------------------------------------------------------------
// pnh_pkg
// Shared constants, types and hash helpers of the 2D noise height sampler.
// ----------------------------------------------------------------------------
package pnh_pkg;

  localparam int NS_W     = 13;
  localparam int FREQ_W   = 16;
  localparam int CFG_W    = 32;
  localparam int CFG_IDX_W = 2;
  localparam int OFS_W    = 17;
  localparam int HEIGHT_W = 19;

  localparam logic [63:0] HASH_M        = 64'h8803_55f2_1e6d_1965;
  localparam logic [63:0] HASH_MIX      = 64'h2127_599b_f432_5c37;
  // The hash is always run over an eight byte key, so the length term is fixed.
  localparam logic [63:0] HASH_SEED_MIX = HASH_M << 3;
  localparam logic [63:0] SEED_B_FLIP   = 64'h1 << 63;
  localparam logic [31:0] HASH_DEN      = 32'hFFFF_FFFF;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PAGE_OFFSET_X,
    CFG_PAGE_OFFSET_Y,
    CFG_FREQUENCY,
    CFG_SAMPLE_COUNT
  } cfg_reg_t;

  // Partial products of a 64 x 64 multiply, low 64 bits of the result only.
  typedef struct packed {
    logic [63:0] ll;
    logic [31:0] lh;
    logic [31:0] hl;
  } pprod_t;

  function automatic pprod_t pp_mul(input logic [63:0] a, input logic [63:0] b);
    pprod_t p;
    p.ll = 64'(a[31:0]) * 64'(b[31:0]);
    p.lh = a[31:0] * b[63:32];
    p.hl = a[63:32] * b[31:0];
    return p;
  endfunction

  function automatic logic [63:0] pp_sum(input pprod_t p);
    return p.ll + {p.lh + p.hl, 32'h0};
  endfunction

  function automatic logic [63:0] xs23(input logic [63:0] h);
    return h ^ (h >> 23);
  endfunction

  // Low word of g ^ (g >> 47).
  function automatic logic [31:0] fold47(input logic [63:0] g);
    return g[31:0] ^ {15'h0, g[63:47]};
  endfunction

endpackage

// ===== rtl/core/pnh_div.sv =====
// ----------------------------------------------------------------------------
// pnh_div
// Pipelined restoring divider, one quotient bit per register stage.
// ----------------------------------------------------------------------------
module pnh_div #(
  parameter int DIV_W = 45
) (
  input  logic                     clk,
  input  logic                     en,
  input  logic [DIV_W-1:0]         dividend,
  input  logic [pnh_pkg::NS_W-1:0] divisor,
  output logic [DIV_W-1:0]         quotient
);

  localparam int NW = pnh_pkg::NS_W;

  logic [NW-1:0]    rem [DIV_W];
  logic [DIV_W-1:0] acc [DIV_W];

  for (genvar i = 0; i < DIV_W; i++) begin : g_step
    logic [NW-1:0]    rem_in;
    logic [DIV_W-1:0] acc_in;
    logic [NW:0]      trial;
    logic             fits;

    if (i == 0) begin : g_first
      assign rem_in = '0;
      assign acc_in = dividend;
    end else begin : g_next
      assign rem_in = rem[i-1];
      assign acc_in = acc[i-1];
    end

    assign trial = {rem_in, acc_in[DIV_W-1]};
    assign fits  = trial >= {1'b0, divisor};

    // The quotient bits shift in from the bottom as the dividend shifts out.
    always_ff @(posedge clk) begin
      if (en) begin
        rem[i] <= fits ? NW'(trial - {1'b0, divisor}) : trial[NW-1:0];
        acc[i] <= {acc_in[DIV_W-2:0], fits};
      end
    end
  end

  assign quotient = acc[DIV_W-1];

endmodule

// ===== rtl/core/pnh_hash.sv =====
// ----------------------------------------------------------------------------
// pnh_hash
// Corner gradient: two seeded 64-bit hashes of one grid key, mapped to Q1.F.
// ----------------------------------------------------------------------------
module pnh_hash #(
  parameter int FRAC_BITS = 16
) (
  input  logic                         clk,
  input  logic                         en,
  input  logic [pnh_pkg::FREQ_W-1:0]   frequency,
  input  logic [63:0]                  key,
  input  logic                         far,
  output logic signed [FRAC_BITS+1:0]  grad_x,
  output logic signed [FRAC_BITS+1:0]  grad_y
);

  localparam int G_W   = FRAC_BITS + 2;
  localparam int NUM_W = 32 + FRAC_BITS + 2;
  localparam logic signed [G_W-1:0] ONE_G = G_W'(1) <<< FRAC_BITS;

  // round(h * 2^(F+1) / (2^32-1)) - 2^F. With num = a*2^32 + b the quotient
  // is a, plus one when a + b reaches the divisor.
  function automatic logic signed [G_W-1:0] to_q(input logic [31:0] h);
    logic [NUM_W-1:0] num;
    logic [G_W-1:0]   a;
    logic [32:0]      sum;
    logic [G_W-1:0]   q;
    num = NUM_W'({h, {(FRAC_BITS + 1){1'b0}}}) + NUM_W'(pnh_pkg::HASH_DEN >> 1);
    a   = num[NUM_W-1:32];
    sum = 33'(a) + 33'(num[31:0]);
    q   = a + G_W'(sum >= 33'(pnh_pkg::HASH_DEN));
    return $signed(G_W'(q - G_W'(ONE_G)));
  endfunction

  logic [63:0]      key_r;
  logic [6:0]       far_d;
  pnh_pkg::pprod_t  pp_k;
  pnh_pkg::pprod_t  pp_a;
  pnh_pkg::pprod_t  pp_b;
  pnh_pkg::pprod_t  pp_a2;
  pnh_pkg::pprod_t  pp_b2;
  logic [63:0]      gk;
  logic [63:0]      ma;
  logic [63:0]      mb;
  logic [31:0]      ha32;
  logic [31:0]      hb32;
  logic [63:0]      mk;
  logic [63:0]      seed_a;
  logic [63:0]      seed_b;

  // The key mix is shared by both seeds.
  assign mk     = gk ^ (gk >> 47);
  assign seed_a = {48'h0, frequency} ^ pnh_pkg::HASH_SEED_MIX ^ mk;
  assign seed_b = seed_a ^ pnh_pkg::SEED_B_FLIP;

  always_ff @(posedge clk) begin
    if (en) begin
      key_r  <= key;
      far_d  <= {far_d[5:0], far};
      pp_k   <= pnh_pkg::pp_mul(pnh_pkg::xs23(key_r), pnh_pkg::HASH_MIX);
      gk     <= pnh_pkg::pp_sum(pp_k);
      pp_a   <= pnh_pkg::pp_mul(seed_a, pnh_pkg::HASH_M);
      pp_b   <= pnh_pkg::pp_mul(seed_b, pnh_pkg::HASH_M);
      ma     <= pnh_pkg::pp_sum(pp_a);
      mb     <= pnh_pkg::pp_sum(pp_b);
      pp_a2  <= pnh_pkg::pp_mul(pnh_pkg::xs23(ma), pnh_pkg::HASH_MIX);
      pp_b2  <= pnh_pkg::pp_mul(pnh_pkg::xs23(mb), pnh_pkg::HASH_MIX);
      ha32   <= pnh_pkg::fold47(pnh_pkg::pp_sum(pp_a2));
      hb32   <= pnh_pkg::fold47(pnh_pkg::pp_sum(pp_b2));
      grad_x <= far_d[6] ? ONE_G : to_q(ha32);
      grad_y <= far_d[6] ? G_W'(0) : to_q(hb32);
    end
  end

endmodule

// ===== rtl/core/perlin_noise_height_2d.sv =====
// ----------------------------------------------------------------------------
// perlin_noise_height_2d
// Fixed-point 2D gradient noise height sampler, fully pipelined.
// ----------------------------------------------------------------------------
// The block takes one sample request per clock and returns one height per
// request, in order. Its depth comes mostly from the two restoring dividers
// by the sample count, which are DIV_W bits wide (the width of the scaled
// grid position) and retire one quotient bit per stage, followed by the
// eight-stage corner hash and the blend stages. Any stall on the output holds
// the whole pipeline in place. Configuration must be written while no
// request is in flight.
module perlin_noise_height_2d #(
  parameter int SAMPLE_BITS = 12,
  parameter int FRAC_BITS   = 16
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [SAMPLE_BITS-1:0]            sample_x,
  input  logic [SAMPLE_BITS-1:0]            sample_y,
  input  logic [FRAC_BITS:0]                offset_x_frac,
  input  logic [FRAC_BITS:0]                offset_y_frac,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic signed [FRAC_BITS+2:0]       height,
  input  logic                              cfg_we,
  input  logic [pnh_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [pnh_pkg::CFG_W-1:0]         cfg_data
);

  localparam int F        = FRAC_BITS;
  localparam int SB       = SAMPLE_BITS;
  localparam int O_W      = F + 1;
  localparam int H_W      = F + 3;
  localparam int P_W      = ((SB + F > O_W) ? SB + F : O_W) + 1;
  localparam int DIV_W    = P_W + pnh_pkg::FREQ_W;
  localparam int G_W      = F + 2;
  localparam int D_W      = F + 2;
  localparam int V_W      = F + 3;
  localparam int CP_W     = 2 * F + 4;
  localparam int CS_W     = 2 * F + 5;
  localparam int T_W      = F + 5;
  localparam int FP_W     = T_W + F + 1;
  localparam int W_W      = F + 1;
  localparam int L_W      = F + 6;
  localparam int LP_W     = L_W + F + 2;
  localparam int HASH_LAT = 8;
  localparam int IDX_TC   = 2 + DIV_W;
  localparam int NSTAGE   = IDX_TC + 15;

  localparam logic signed [D_W-1:0]  ONE_D   = D_W'(1) <<< F;
  localparam logic signed [T_W-1:0]  ONE_T   = T_W'(1) <<< F;
  localparam logic signed [T_W-1:0]  TEN_T   = T_W'(10) <<< F;
  localparam logic signed [T_W-1:0]  FIFT_T  = T_W'(15) <<< F;
  localparam logic signed [FP_W-1:0] HALF_FP = FP_W'(1) <<< (F - 1);
  localparam logic signed [CS_W-1:0] HALF_CS = CS_W'(1) <<< (F - 1);
  localparam logic signed [LP_W-1:0] HALF_LP = LP_W'(1) <<< (F - 1);
  localparam logic [W_W-1:0]         ONE_W   = W_W'(1) << F;
  localparam logic signed [L_W-1:0]  TWO_L   = L_W'(2) <<< F;

  function automatic logic signed [T_W-1:0] fade_mul(input logic signed [T_W-1:0] t,
                                                     input logic signed [F:0] s);
    logic signed [FP_W-1:0] prod;
    prod = FP_W'(t) * FP_W'(s);
    prod = prod + HALF_FP;
    return T_W'(prod >>> F);
  endfunction

  function automatic logic signed [LP_W-1:0] lerp_prod(input logic signed [L_W-1:0] a,
                                                       input logic signed [L_W-1:0] b,
                                                       input logic [W_W-1:0] w);
    logic signed [L_W-1:0] diff;
    diff = b - a;
    return LP_W'(diff) * LP_W'($signed({1'b0, w}));
  endfunction

  function automatic logic signed [L_W-1:0] lerp_fin(input logic signed [L_W-1:0] a,
                                                     input logic signed [LP_W-1:0] p);
    return a + L_W'((p + HALF_LP) >>> F);
  endfunction

  // Configuration.
  logic [31:0]                  page_x;
  logic [31:0]                  page_y;
  logic [pnh_pkg::FREQ_W-1:0]   freq;
  logic [pnh_pkg::NS_W-1:0]     nsamp;
  logic [pnh_pkg::NS_W-1:0]     n_eff;
  logic [31:0]                  base_x;
  logic [31:0]                  base_y;

  always_ff @(posedge clk) begin
    if (rst) begin
      page_x <= '0;
      page_y <= '0;
      freq   <= pnh_pkg::FREQ_W'(1);
      nsamp  <= pnh_pkg::NS_W'(1);
    end else if (cfg_we) begin
      case (pnh_pkg::cfg_reg_t'(cfg_index))
        pnh_pkg::CFG_PAGE_OFFSET_X: page_x <= cfg_data;
        pnh_pkg::CFG_PAGE_OFFSET_Y: page_y <= cfg_data;
        pnh_pkg::CFG_FREQUENCY:     freq   <= cfg_data[pnh_pkg::FREQ_W-1:0];
        pnh_pkg::CFG_SAMPLE_COUNT:  nsamp  <= cfg_data[pnh_pkg::NS_W-1:0];
        default: ;
      endcase
    end
  end

  // Page base in grid cells, registered; it settles in the cycle after a write.
  always_ff @(posedge clk) begin
    base_x <= page_x * 32'(freq);
    base_y <= page_y * 32'(freq);
  end

  assign n_eff = (nsamp == '0) ? pnh_pkg::NS_W'(1) : nsamp;

  // Pipeline control.
  logic              en;
  logic [NSTAGE-1:0] vld;

  assign en        = !vld[NSTAGE-1] || out_ready;
  assign in_ready  = en;
  assign out_valid = vld[NSTAGE-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[NSTAGE-2:0], in_valid};
    end
  end

  // Input register and scaled position.
  logic [SB-1:0]             sx_r;
  logic [SB-1:0]             sy_r;
  logic [O_W-1:0]            ox_r;
  logic [O_W-1:0]            oy_r;
  logic [DIV_W-1:0]          prod_x;
  logic [DIV_W-1:0]          prod_y;
  logic [P_W-1:0]            px;
  logic [P_W-1:0]            py;

  assign px = P_W'({sx_r, {F{1'b0}}}) + P_W'(ox_r);
  assign py = P_W'({sy_r, {F{1'b0}}}) + P_W'(oy_r);

  always_ff @(posedge clk) begin
    if (en) begin
      sx_r   <= sample_x;
      sy_r   <= sample_y;
      ox_r   <= offset_x_frac;
      oy_r   <= offset_y_frac;
      prod_x <= DIV_W'(px) * DIV_W'(freq);
      prod_y <= DIV_W'(py) * DIV_W'(freq);
    end
  end

  logic [DIV_W-1:0] qx;
  logic [DIV_W-1:0] qy;

  pnh_div #(.DIV_W(DIV_W)) u_div_x (
    .clk      (clk),
    .en       (en),
    .dividend (prod_x),
    .divisor  (n_eff),
    .quotient (qx)
  );

  pnh_div #(.DIV_W(DIV_W)) u_div_y (
    .clk      (clk),
    .en       (en),
    .dividend (prod_y),
    .divisor  (n_eff),
    .quotient (qy)
  );

  // Cell split, corner keys and range checks.
  logic [DIV_W+31:0] qx_ext;
  logic [DIV_W+31:0] qy_ext;
  logic [31:0]       cx;
  logic [31:0]       cy;
  logic [31:0]       cx1;
  logic [31:0]       cy1;
  logic [31:0]       freq32;
  logic [31:0]       tx0;
  logic [31:0]       tx1;
  logic [31:0]       ty0;
  logic [31:0]       ty1;
  logic [3:0]        far_c;
  logic [F-1:0]      fdl [2][HASH_LAT+1];

  assign qx_ext = {32'h0, qx};
  assign qy_ext = {32'h0, qy};
  assign cx     = qx_ext[F+31:F];
  assign cy     = qy_ext[F+31:F];
  assign cx1    = cx + 32'd1;
  assign cy1    = cy + 32'd1;
  assign freq32 = 32'(freq);

  // Corners are ordered (x,y), (x+1,y), (x,y+1), (x+1,y+1).
  always_ff @(posedge clk) begin
    if (en) begin
      tx0      <= base_x + cx;
      tx1      <= base_x + cx1;
      ty0      <= base_y + cy;
      ty1      <= base_y + cy1;
      far_c[0] <= (cx > freq32) || (cy > freq32);
      far_c[1] <= (cx1 > freq32) || (cy > freq32);
      far_c[2] <= (cx > freq32) || (cy1 > freq32);
      far_c[3] <= (cx1 > freq32) || (cy1 > freq32);
      fdl[0][0] <= qx[F-1:0];
      fdl[1][0] <= qy[F-1:0];
      for (int k = 1; k <= HASH_LAT; k++) begin
        fdl[0][k] <= fdl[0][k-1];
        fdl[1][k] <= fdl[1][k-1];
      end
    end
  end

  logic signed [G_W-1:0] gx [4];
  logic signed [G_W-1:0] gy [4];

  for (genvar c = 0; c < 4; c++) begin : g_corner
    localparam bit SEL_X = (c % 2) == 1;
    localparam bit SEL_Y = (c / 2) == 1;
    logic [31:0] tx;
    logic [31:0] ty;
    logic [63:0] key;

    assign tx  = SEL_X ? tx1 : tx0;
    assign ty  = SEL_Y ? ty1 : ty0;
    // The low word is sign-extended into the high word before the add.
    assign key = {ty - {31'h0, tx[31]}, tx};

    pnh_hash #(.FRAC_BITS(F)) u_hash (
      .clk       (clk),
      .en        (en),
      .frequency (freq),
      .key       (key),
      .far       (far_c[c]),
      .grad_x    (gx[c]),
      .grad_y    (gy[c])
    );
  end

  // Fade weights, computed while the hashes run.
  logic signed [T_W-1:0] ft [2][4];
  logic [W_W-1:0]        w_x [6];
  logic [W_W-1:0]        w_y [8];
  logic [W_W-1:0]        w_new [2];

  always_comb begin
    logic signed [T_W-1:0] t;
    for (int d = 0; d < 2; d++) begin
      t = fade_mul(ft[d][3], $signed({1'b0, fdl[d][4]}));
      if (t < 0) begin
        w_new[d] = '0;
      end else if (t > ONE_T) begin
        w_new[d] = ONE_W;
      end else begin
        w_new[d] = t[F:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int d = 0; d < 2; d++) begin
        ft[d][0] <= T_W'($signed({1'b0, fdl[d][0]})) * T_W'(6) - FIFT_T;
        ft[d][1] <= fade_mul(ft[d][0], $signed({1'b0, fdl[d][1]})) + TEN_T;
        ft[d][2] <= fade_mul(ft[d][1], $signed({1'b0, fdl[d][2]}));
        ft[d][3] <= fade_mul(ft[d][2], $signed({1'b0, fdl[d][3]}));
      end
      w_x[0] <= w_new[0];
      w_y[0] <= w_new[1];
      for (int j = 1; j < 6; j++) begin
        w_x[j] <= w_x[j-1];
      end
      for (int j = 1; j < 8; j++) begin
        w_y[j] <= w_y[j-1];
      end
    end
  end

  // Corner dot products.
  logic signed [D_W-1:0]  dx0;
  logic signed [D_W-1:0]  dx1;
  logic signed [D_W-1:0]  dy0;
  logic signed [D_W-1:0]  dy1;
  logic signed [CP_W-1:0] cpx [4];
  logic signed [CP_W-1:0] cpy [4];
  logic signed [V_W-1:0]  vc  [4];

  assign dx0 = $signed({2'b00, fdl[0][HASH_LAT]});
  assign dy0 = $signed({2'b00, fdl[1][HASH_LAT]});
  assign dx1 = dx0 - ONE_D;
  assign dy1 = dy0 - ONE_D;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int c = 0; c < 4; c++) begin
        cpx[c] <= CP_W'(gx[c]) * CP_W'(((c % 2) == 1) ? dx1 : dx0);
        cpy[c] <= CP_W'(gy[c]) * CP_W'(((c / 2) == 1) ? dy1 : dy0);
        vc[c]  <= V_W'((CS_W'(cpx[c]) + CS_W'(cpy[c]) + HALF_CS) >>> F);
      end
    end
  end

  // Bilinear blend with the fade weights, then saturation.
  logic signed [LP_W-1:0] lpx0;
  logic signed [LP_W-1:0] lpx1;
  logic signed [L_W-1:0]  ax0;
  logic signed [L_W-1:0]  ax1;
  logic signed [L_W-1:0]  lx0;
  logic signed [L_W-1:0]  lx1;
  logic signed [LP_W-1:0] lpy;
  logic signed [L_W-1:0]  ay;
  logic signed [L_W-1:0]  hsum;
  logic signed [L_W-1:0]  hsat;

  assign hsum = lerp_fin(ay, lpy);

  always_comb begin
    if (hsum > TWO_L) begin
      hsat = TWO_L;
    end else if (hsum < -TWO_L) begin
      hsat = -TWO_L;
    end else begin
      hsat = hsum;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      lpx0   <= lerp_prod(L_W'(vc[0]), L_W'(vc[1]), w_x[5]);
      lpx1   <= lerp_prod(L_W'(vc[2]), L_W'(vc[3]), w_x[5]);
      ax0    <= L_W'(vc[0]);
      ax1    <= L_W'(vc[2]);
      lx0    <= lerp_fin(ax0, lpx0);
      lx1    <= lerp_fin(ax1, lpx1);
      lpy    <= lerp_prod(lx0, lx1, w_y[7]);
      ay     <= lx0;
      height <= H_W'(hsat);
    end
  end

  // A fade weight never leaves the unit interval.
  a_fade_range: assert property (@(posedge clk) disable iff (rst)
    vld[IDX_TC+5] |-> (w_x[0] <= ONE_W) && (w_y[0] <= ONE_W))
    else $error("fade weight out of range");

  // A held output freezes every stage, so no request is lost or duplicated.
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    !en |=> $stable(vld))
    else $error("pipeline moved during a stall");

  // The blended height stays within the saturation bounds.
  a_height_sat: assert property (@(posedge clk) disable iff (rst)
    vld[NSTAGE-2] |-> (hsat <= TWO_L) && (hsat >= -TWO_L))
    else $error("height outside saturation bounds");

endmodule

// ===== test/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the 2D noise height sampler. Sample requests go in
// through a queued driver, and every height is checked in order against a
// bit-exact fixed-point predictor. The bench also steps through several
// register settings and patterns of idle and stall cycles.
// ----------------------------------------------------------------------------
module tb;

  localparam longint ONE_Q = 64'sd65536;
  localparam longint HALF_Q = 64'sd32768;
  localparam int LATENCY = 62;

  typedef struct {
    bit [11:0] sx;
    bit [11:0] sy;
    bit [16:0] ox;
    bit [16:0] oy;
  } sample_req_t;

  logic clk;
  logic rst;
  logic in_valid;
  logic in_ready;
  logic [11:0] sample_x;
  logic [11:0] sample_y;
  logic [pnh_pkg::OFS_W-1:0] offset_x_frac;
  logic [pnh_pkg::OFS_W-1:0] offset_y_frac;
  logic out_valid;
  logic out_ready;
  logic signed [pnh_pkg::HEIGHT_W-1:0] height;
  logic cfg_we;
  logic [pnh_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [pnh_pkg::CFG_W-1:0] cfg_data;

  perlin_noise_height_2d dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .sample_x(sample_x), .sample_y(sample_y),
    .offset_x_frac(offset_x_frac), .offset_y_frac(offset_y_frac),
    .out_valid(out_valid), .out_ready(out_ready), .height(height),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // Predictor copy of the registers.
  bit [31:0] pg_x;
  bit [31:0] pg_y;
  bit [15:0] freq;
  bit [12:0] nsamp;

  sample_req_t req_q[$];
  bit [18:0] height_q[$];
  bit in_fire = 0;
  int idle_pct = 0;
  int stall_pct = 0;
  bit long_hold_go = 0;
  bit long_hold_done = 0;
  int hold_cnt = 0;
  int errors = 0;
  int mismatches = 0;
  int n_req = 0;
  int n_res = 0;

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  initial begin
    #3ms;
    $display("timeout with %0d heights outstanding", height_q.size());
    $display("** perlin_noise_height_2d: FAILED **");
    $finish;
  end

  function automatic bit [63:0] mix64(bit [63:0] h);
    h = h ^ (h >> 23);
    h = h * pnh_pkg::HASH_MIX;
    h = h ^ (h >> 47);
    return h;
  endfunction

  function automatic bit [31:0] fast_hash(bit [63:0] key, bit [63:0] seed);
    bit [63:0] h;
    h = seed ^ (pnh_pkg::HASH_M * 64'd8);
    h = h ^ mix64(key);
    h = h * pnh_pkg::HASH_M;
    h = mix64(h);
    return h[31:0];
  endfunction

  // Maps a 32-bit hash onto [-1, 1] in Q1.16, rounded to nearest.
  function automatic longint grad_q(bit [31:0] h);
    bit [63:0] num;
    num = ({32'b0, h} << 17) + 64'h7FFF_FFFF;
    return longint'(num / 64'hFFFF_FFFF) - ONE_Q;
  endfunction

  function automatic longint qmul(longint a, longint b);
    return (a * b + HALF_Q) >>> 16;
  endfunction

  function automatic longint fade_q(longint s);
    longint t;
    t = 6 * s - 15 * ONE_Q;
    t = qmul(t, s) + 10 * ONE_Q;
    t = qmul(t, s);
    t = qmul(t, s);
    t = qmul(t, s);
    if (t < 0) t = 0;
    if (t > ONE_Q) t = ONE_Q;
    return t;
  endfunction

  function automatic longint corner_dot(bit [31:0] cx, bit [31:0] cy, longint dx, longint dy);
    longint gx;
    longint gy;
    bit [31:0] tx;
    bit [31:0] ty;
    bit [63:0] key;
    // Corners past the grid edge fall back to a fixed gradient along x.
    if (cx > {16'b0, freq} || cy > {16'b0, freq}) begin
      gx = ONE_Q;
      gy = 0;
    end else begin
      tx = pg_x * {16'b0, freq} + cx;
      ty = pg_y * {16'b0, freq} + cy;
      key = {{32{tx[31]}}, tx} + {ty, 32'b0};
      gx = grad_q(fast_hash(key, {48'b0, freq}));
      gy = grad_q(fast_hash(key, {48'b0, freq} ^ pnh_pkg::SEED_B_FLIP));
    end
    return (gx * dx + gy * dy + HALF_Q) >>> 16;
  endfunction

  function automatic bit [63:0] grid_pos(bit [11:0] s, bit [16:0] o);
    bit [63:0] n;
    bit [63:0] p;
    n = (nsamp == 0) ? 64'd1 : {51'b0, nsamp};
    p = ({52'b0, s} << 16) + {47'b0, o};
    return p * {48'b0, freq} / n;
  endfunction

  function automatic bit [18:0] predict_height(sample_req_t r);
    bit [63:0] px;
    bit [63:0] py;
    bit [31:0] cx;
    bit [31:0] cy;
    longint fx;
    longint fy;
    longint v00, v10, v01, v11, wx, wy, h;
    px = grid_pos(r.sx, r.ox);
    py = grid_pos(r.sy, r.oy);
    cx = px[47:16];
    cy = py[47:16];
    fx = longint'({48'b0, px[15:0]});
    fy = longint'({48'b0, py[15:0]});
    v00 = corner_dot(cx, cy, fx, fy);
    v10 = corner_dot(cx + 1, cy, fx - ONE_Q, fy);
    v01 = corner_dot(cx, cy + 1, fx, fy - ONE_Q);
    v11 = corner_dot(cx + 1, cy + 1, fx - ONE_Q, fy - ONE_Q);
    wx = fade_q(fx);
    wy = fade_q(fy);
    v00 = v00 + qmul(v10 - v00, wx);
    v01 = v01 + qmul(v11 - v01, wx);
    h = v00 + qmul(v01 - v00, wy);
    if (h > 2 * ONE_Q) h = 2 * ONE_Q;
    if (h < -2 * ONE_Q) h = -2 * ONE_Q;
    return h[18:0];
  endfunction

  // Request and result monitor.
  always @(posedge clk) begin
    in_fire = !rst && in_valid && in_ready;
    if (in_fire) begin
      height_q.push_back(predict_height('{sample_x, sample_y, offset_x_frac, offset_y_frac}));
      n_req++;
    end
    if (!rst && out_valid && out_ready) begin
      n_res++;
      if (height_q.size() == 0) begin
        errors++;
        $display("height %0d arrived with no request outstanding", height);
      end else if (height_q[0] != height) begin
        errors++;
        mismatches++;
        if (mismatches <= 10)
          $display("height mismatch: expected %0d, got %0d",
                   $signed(height_q[0]), height);
        void'(height_q.pop_front());
      end else begin
        void'(height_q.pop_front());
      end
    end
  end

  // Request driver.
  always @(negedge clk) begin
    sample_req_t r;
    if (rst) begin
      in_valid <= 0;
    end else if (!in_valid || in_fire) begin
      if (req_q.size() > 0 && $urandom_range(99) >= idle_pct) begin
        r = req_q.pop_front();
        sample_x <= r.sx;
        sample_y <= r.sy;
        offset_x_frac <= r.ox;
        offset_y_frac <= r.oy;
        in_valid <= 1;
      end else begin
        in_valid <= 0;
      end
    end
  end

  // Result receiver, including one long hold-off that backs up the pipeline.
  always @(negedge clk) begin
    if (long_hold_go && !long_hold_done) begin
      long_hold_done = 1;
      hold_cnt = 400;
    end
    if (hold_cnt > 0) begin
      hold_cnt--;
      out_ready <= 0;
    end else begin
      out_ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  task automatic write_reg(pnh_pkg::cfg_reg_t idx, bit [31:0] val);
    @(negedge clk);
    cfg_we <= 1;
    cfg_index <= idx;
    cfg_data <= val;
    case (idx)
      pnh_pkg::CFG_PAGE_OFFSET_X: pg_x = val;
      pnh_pkg::CFG_PAGE_OFFSET_Y: pg_y = val;
      pnh_pkg::CFG_FREQUENCY: freq = val[15:0];
      pnh_pkg::CFG_SAMPLE_COUNT: nsamp = val[12:0];
      default: ;
    endcase
  endtask

  task automatic configure(bit [31:0] px, bit [31:0] py, bit [31:0] f, bit [31:0] n);
    write_reg(pnh_pkg::CFG_PAGE_OFFSET_X, px);
    write_reg(pnh_pkg::CFG_PAGE_OFFSET_Y, py);
    write_reg(pnh_pkg::CFG_FREQUENCY, f);
    write_reg(pnh_pkg::CFG_SAMPLE_COUNT, n);
    @(negedge clk);
    cfg_we <= 0;
  endtask

  task automatic push_req(bit [11:0] sx, bit [11:0] sy, bit [16:0] ox, bit [16:0] oy);
    req_q.push_back('{sx, sy, ox, oy});
  endtask

  function automatic bit [16:0] rand_offset();
    int k;
    k = $urandom_range(99);
    if (k < 80) return 17'($urandom_range(65535));
    if (k < 88) return 17'd65536;
    if (k < 94) return 17'd0;
    return 17'($urandom_range(131071));
  endfunction

  function automatic bit [11:0] rand_sample();
    int n;
    n = (nsamp == 0) ? 1 : int'(nsamp);
    if (n > 4096) n = 4096;
    if ($urandom_range(9) == 0) return 12'($urandom_range(4095));
    return 12'($urandom_range(n - 1));
  endfunction

  task automatic drain();
    wait (req_q.size() == 0 && !in_valid && height_q.size() == 0);
    repeat (LATENCY + 10) @(posedge clk);
  endtask

  initial begin
    bit [31:0] cfg_set[8][4];
    int phase;
    int i;
    int n_first;
    rst = 1;
    in_valid = 0;
    out_ready = 0;
    sample_x = 0;
    sample_y = 0;
    offset_x_frac = 0;
    offset_y_frac = 0;
    cfg_we = 0;
    cfg_index = 0;
    cfg_data = 0;
    pg_x = 0;
    pg_y = 0;
    freq = 1;
    nsamp = 1;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 0;

    // Directed part at the reset settings: field extremes, offsets at and past
    // one, and samples far beyond the page so that corners leave the grid.
    push_req(0, 0, 0, 0);
    push_req(0, 0, 17'd65536, 17'd65536);
    push_req(0, 0, 17'd131071, 17'd131071);
    push_req(0, 0, 17'd32768, 17'd16384);
    push_req(0, 0, 17'd65535, 17'd1);
    push_req(12'd4095, 12'd4095, 17'd131071, 17'd131071);
    push_req(12'd4095, 0, 0, 17'd40000);
    push_req(0, 12'd4095, 17'd12345, 0);
    push_req(12'd2730, 12'd1365, 17'h0AAAA, 17'h15555);
    drain();

    // Zero frequency and zero sample count.
    configure(32'h1234_5678, 32'h8765_4321, 0, 0);
    push_req(0, 0, 17'd30000, 17'd50000);
    push_req(12'd4095, 12'd4095, 17'd131071, 17'd131071);
    push_req(12'd100, 12'd7, 17'd65536, 0);
    drain();

    // Largest frequency against one sample per page, with page extremes.
    configure(32'h8000_0000, 32'h7FFF_FFFF, 32'd65535, 32'd1);
    push_req(0, 0, 17'd1, 17'd65535);
    push_req(0, 0, 17'd65536, 17'd65536);
    push_req(12'd1, 12'd1, 0, 0);
    push_req(0, 0, 17'h1FFFF, 17'h10000);
    drain();

    cfg_set[0] = '{32'd0, 32'd0, 32'd8, 32'd64};
    cfg_set[1] = '{32'hFFFF_FFFF, 32'd3, 32'd16, 32'd4096};
    cfg_set[2] = '{32'h7FFF_FFFF, 32'h8000_0000, 32'd1, 32'd4096};
    cfg_set[3] = '{32'd0, 32'd0, 32'd65535, 32'd4096};
    cfg_set[4] = '{32'd0, 32'd0, 32'd4, 32'd5};
    cfg_set[5] = '{32'd0, 32'd0, 32'd3, 32'd8191};
    cfg_set[6] = '{32'd0, 32'd0, 32'd0, 32'd1};
    cfg_set[7] = '{32'd0, 32'd0, 32'd0, 32'd0};
    for (phase = 0; phase < 8; phase++) begin
      if (phase < 3) begin
        configure(cfg_set[phase][0], cfg_set[phase][1], cfg_set[phase][2], cfg_set[phase][3]);
      end else begin
        configure(cfg_set[phase][0] ^ $urandom(), cfg_set[phase][1] ^ $urandom(),
                  (phase == 3) ? cfg_set[phase][2] : 32'($urandom_range(1, 65535)),
                  (phase == 5) ? cfg_set[phase][3] : 32'($urandom_range(1, 4096)));
      end
      case (phase % 4)
        0: begin idle_pct = 0; stall_pct = 0; end
        1: begin idle_pct = 52; stall_pct = 0; end
        2: begin idle_pct = 0; stall_pct = 52; end
        default: begin idle_pct = 31; stall_pct = 31; end
      endcase
      // The long hold-off gets more requests than the pipeline holds, so the
      // input backs up while the receiver waits.
      n_first = (phase == 2) ? 150 : 60;
      for (i = 0; i < n_first; i++)
        push_req(rand_sample(), rand_sample(), rand_offset(), rand_offset());
      if (phase == 2) long_hold_go = 1;
      // Pause the sender until every height of the first batch is back.
      wait (req_q.size() == 0 && !in_valid);
      wait (height_q.size() == 0);
      for (i = 0; i < 60; i++)
        push_req(rand_sample(), rand_sample(), rand_offset(), rand_offset());
      drain();
    end

    if (height_q.size() != 0) errors += height_q.size();
    $display("checked %0d heights from %0d requests over 11 register settings,", n_res, n_req);
    $display("including zero frequency, zero sample count and page offset extremes");
    if (errors == 0)
      $display("** perlin_noise_height_2d: PASSED **");
    else
      $display("** perlin_noise_height_2d: FAILED **");
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/core/pnh_pkg.sv
rtl/core/pnh_div.sv
rtl/core/pnh_hash.sv
rtl/core/perlin_noise_height_2d.sv
test/tb.sv
